FILE: rtl/spr_pkg.sv
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types and constants of the segment pixel span rasterizer.
// ----------------------------------------------------------------------------
package spr_pkg;

    localparam int DEFAULT_MAX_DIM = 64;
    localparam int DIV_NUM_W       = 128;
    localparam int DIV_DEN_W       = 64;

    typedef struct packed {
        logic [31:0] origin_x;
        logic [31:0] origin_y;
        logic [31:0] scale_x;
        logic [31:0] scale_y;
        logic [6:0]  image_width;
        logic [6:0]  image_height;
    } t_cfg;

    typedef struct packed {
        logic [5:0] y_final;
        logic [5:0] y_first;
        logic [5:0] x_final;
        logic [5:0] x_first;
    } t_run;

    typedef enum logic [3:0] {
        MUL_PX0, MUL_PX1, MUL_PY0, MUL_PY1, MUL_DX, MUL_DY,
        MUL_LL, MUL_LH, MUL_HL, MUL_HH
    } t_mulop;

    typedef enum logic [1:0] {
        SRC_SINGLE, SRC_FIRST, SRC_LOOP, SRC_LAST
    } t_src;

    typedef enum logic {
        DSEL_PRODUCT, DSEL_STEP
    } t_dsel;

    typedef struct packed {
        logic   load;
        logic   mul_en;
        t_mulop mul_op;
        logic   classify;
        logic   order;
        logic   prep;
        logic   div_start;
        t_dsel  div_sel;
        logic   save_q0;
        logic   save_step;
        logic   first_init;
        logic   advance;
        logic   step_next;
        logic   emit;
        t_src   src;
        logic   flush;
    } t_cmd;

    typedef struct packed {
        logic reject;
        logic single;
        logic first_ok;
        logic last_ok;
        logic j_lt_stop;
        logic div_busy;
        logic cand_nonempty;
    } t_sts;

endpackage

FILE: rtl/segment_pixel_span_raster_top.sv
// ----------------------------------------------------------------------------
// segment_pixel_span_raster_top
// Rasterizes a segment into clipped pixel runs along its shorter axis.
//
//   channel | dir | handshake               | contents
//   s_axis  | in  | tvalid/tready           | one segment, four Q16.16 coordinates
//   m_axis  | out | tvalid/tready, tlast    | one run, tlast on the final run
//   apb     | in  | psel/penable/pready     | origin, scale, image size
//
// A segment that is neither rejected nor single-step passes through two
// divisions of the divider before stepping; rejected or single-step
// segments skip them.
// Reset is synchronous and returns the registers to their defaults.
// A stalled output holds the stepping loop until the run is taken.
// ----------------------------------------------------------------------------
module segment_pixel_span_raster_top
    import spr_pkg::*;
#(
    parameter int MAX_DIM = DEFAULT_MAX_DIM
)
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // x_start, y_start, x_end, y_end
    input  logic [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // x_first, x_final, y_first, y_final
    output logic [23:0]  m_axis_tdata,
    output logic         m_axis_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam logic [2:0] REG_ORIGIN_X     = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y     = 3'd1;
    localparam logic [2:0] REG_SCALE_X      = 3'd2;
    localparam logic [2:0] REG_SCALE_Y      = 3'd3;
    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd4;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd5;

    t_cfg r_cfg;
    t_cmd cmd;
    t_sts sts;
    t_run cand;
    t_run out_run;
    logic buf_ready;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x     <= 32'd0;
            r_cfg.origin_y     <= 32'd0;
            r_cfg.scale_x      <= 32'd65536;
            r_cfg.scale_y      <= 32'd65536;
            r_cfg.image_width  <= 7'd64;
            r_cfg.image_height <= 7'd64;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
                REG_ORIGIN_X:     r_cfg.origin_x     <= pwdata;
                REG_ORIGIN_Y:     r_cfg.origin_y     <= pwdata;
                REG_SCALE_X:      r_cfg.scale_x      <= pwdata;
                REG_SCALE_Y:      r_cfg.scale_y      <= pwdata;
                REG_IMAGE_WIDTH:  r_cfg.image_width  <= pwdata[6:0];
                REG_IMAGE_HEIGHT: r_cfg.image_height <= pwdata[6:0];
                default:          r_cfg <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_ORIGIN_X:     prdata = r_cfg.origin_x;
            REG_ORIGIN_Y:     prdata = r_cfg.origin_y;
            REG_SCALE_X:      prdata = r_cfg.scale_x;
            REG_SCALE_Y:      prdata = r_cfg.scale_y;
            REG_IMAGE_WIDTH:  prdata = {25'd0, r_cfg.image_width};
            REG_IMAGE_HEIGHT: prdata = {25'd0, r_cfg.image_height};
            default:          prdata = 32'd0;
        endcase
    end

    spr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_sts       (sts),
        .i_buf_ready (buf_ready),
        .o_cmd       (cmd)
    );

    spr_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_seg   (s_axis_tdata),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_run   (cand)
    );

    spr_outbuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd.emit && sts.cand_nonempty),
        .i_run   (cand),
        .i_flush (cmd.flush),
        .o_ready (buf_ready),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_run   (out_run),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = out_run;

endmodule

FILE: rtl/spr_div.sv
// ----------------------------------------------------------------------------
// spr_div
// Restoring divider, one quotient bit per cycle, low quotient bits kept.
// ----------------------------------------------------------------------------
module spr_div
    import spr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DIV_DEN_W-1:0] i_den,
    output logic                 o_busy,
    output logic [DIV_DEN_W-1:0] o_quot,
    output logic [DIV_DEN_W-1:0] o_rem
);

    localparam int CW = $clog2(DIV_NUM_W);

    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_DEN_W-1:0] r_rem, r_quo;
    logic [CW-1:0]        r_cnt;
    logic                 r_busy;
    logic [DIV_DEN_W:0]   n_trial;
    logic                 n_bit;

    always_comb begin
        n_trial = {r_rem, r_num[DIV_NUM_W-1]};
        n_bit   = (n_trial >= {1'b0, i_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_num  <= i_num;
            r_rem  <= '0;
            r_quo  <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_NUM_W-2:0], 1'b0};
            r_quo <= {r_quo[DIV_DEN_W-2:0], n_bit};
            if (n_bit) begin
                r_rem <= DIV_DEN_W'(n_trial - {1'b0, i_den});
            end else begin
                r_rem <= n_trial[DIV_DEN_W-1:0];
            end
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(DIV_NUM_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

FILE: rtl/spr_datapath.sv
// ----------------------------------------------------------------------------
// spr_datapath
// Pixel mapping, axis selection, crossing arithmetic and run clipping.
// ----------------------------------------------------------------------------
module spr_datapath
    import spr_pkg::*;
#(
    parameter int MAX_DIM = DEFAULT_MAX_DIM
)
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cfg         i_cfg,
    input  logic [127:0] i_seg,
    input  t_cmd         i_cmd,
    output t_sts         o_sts,
    output t_run         o_run
);

    localparam int NW = $clog2(MAX_DIM + 1);

    logic [31:0] r_x0, r_y0, r_x1, r_y1;
    logic [63:0] r_prod;
    t_mulop      r_pdst;
    logic        r_pv;
    logic [63:0] r_px0, r_px1, r_py0, r_py1, r_dx, r_dy;
    logic        r_swap;
    logic [63:0] r_pa0, r_pa1, r_pb0, r_pb1;
    logic [31:0] r_ja0, r_ja1, r_jb0, r_jb1;
    logic [NW-1:0] r_na, r_nb, r_kb, r_stop, r_j;
    logic [63:0] r_d, r_m, r_n0;
    logic        r_neg;
    logic [127:0] r_acc;
    logic [63:0] r_q, r_r, r_qs, r_rs;
    logic [31:0] r_prev;

    logic [32:0] n_ma, n_mb;
    logic [65:0] n_prod;
    logic [63:0] n_adx, n_ady;
    logic [63:0] n_pa0, n_pa1, n_pb0, n_pb1;
    logic        n_oswap;
    logic [NW-1:0] n_w, n_h, n_kb;
    logic [31:0] na32, nb32;
    logic [63:0] n_cres, n_qnext;
    logic [64:0] n_rsum, n_rnext;
    logic        n_cy;
    logic [31:0] n_cval;
    logic [31:0] n_b0, n_b1, n_lo, n_hi;
    logic [5:0]  n_idx;
    logic signed [32:0] n_loc, n_hic, n_lim;
    logic [127:0] n_dnum;
    logic        div_busy;
    logic [63:0] div_q, div_r;

    spr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (n_dnum),
        .i_den   (r_d),
        .o_busy  (div_busy),
        .o_quot  (div_q),
        .o_rem   (div_r)
    );

    always_comb begin
        n_ma = '0;
        n_mb = '0;
        case (i_cmd.mul_op)
            MUL_PX0: begin
                n_ma = {r_x0[31], r_x0} - {i_cfg.origin_x[31], i_cfg.origin_x};
                n_mb = {i_cfg.scale_x[31], i_cfg.scale_x};
            end
            MUL_PX1: begin
                n_ma = {r_x1[31], r_x1} - {i_cfg.origin_x[31], i_cfg.origin_x};
                n_mb = {i_cfg.scale_x[31], i_cfg.scale_x};
            end
            MUL_PY0: begin
                n_ma = {r_y0[31], r_y0} - {i_cfg.origin_y[31], i_cfg.origin_y};
                n_mb = {i_cfg.scale_y[31], i_cfg.scale_y};
            end
            MUL_PY1: begin
                n_ma = {r_y1[31], r_y1} - {i_cfg.origin_y[31], i_cfg.origin_y};
                n_mb = {i_cfg.scale_y[31], i_cfg.scale_y};
            end
            MUL_DX: begin
                n_ma = {r_x1[31], r_x1} - {r_x0[31], r_x0};
                n_mb = {i_cfg.scale_x[31], i_cfg.scale_x};
            end
            MUL_DY: begin
                n_ma = {r_y1[31], r_y1} - {r_y0[31], r_y0};
                n_mb = {i_cfg.scale_y[31], i_cfg.scale_y};
            end
            MUL_LL: begin
                n_ma = {1'b0, r_n0[31:0]};
                n_mb = {1'b0, r_m[31:0]};
            end
            MUL_LH: begin
                n_ma = {1'b0, r_n0[31:0]};
                n_mb = {1'b0, r_m[63:32]};
            end
            MUL_HL: begin
                n_ma = {1'b0, r_n0[63:32]};
                n_mb = {1'b0, r_m[31:0]};
            end
            MUL_HH: begin
                n_ma = {1'b0, r_n0[63:32]};
                n_mb = {1'b0, r_m[63:32]};
            end
            default: begin
                n_ma = '0;
                n_mb = '0;
            end
        endcase
        n_prod = 66'($signed(n_ma) * $signed(n_mb));
    end

    always_comb begin
        n_adx = r_dx[63] ? (64'd0 - r_dx) : r_dx;
        n_ady = r_dy[63] ? (64'd0 - r_dy) : r_dy;
        n_w = (i_cfg.image_width > 7'(MAX_DIM)) ? NW'(MAX_DIM)
                                                 : NW'(i_cfg.image_width);
        n_h = (i_cfg.image_height > 7'(MAX_DIM)) ? NW'(MAX_DIM)
                                                  : NW'(i_cfg.image_height);
        n_pa0 = r_swap ? r_py0 : r_px0;
        n_pa1 = r_swap ? r_py1 : r_px1;
        n_pb0 = r_swap ? r_px0 : r_py0;
        n_pb1 = r_swap ? r_px1 : r_py1;
        n_oswap = $signed(n_pa1[63:32]) < $signed(n_pa0[63:32]);
        na32 = {{(32-NW){1'b0}}, r_na};
        nb32 = {{(32-NW){1'b0}}, r_nb};
        n_kb = r_ja0[31] ? '0 : NW'(r_ja0 + 32'd1);
        n_dnum = (i_cmd.div_sel == DSEL_STEP) ? {32'd0, r_m, 32'd0} : r_acc;
    end

    always_comb begin
        if (r_neg) begin
            n_cres = r_pb0 - (r_q + {63'd0, (r_r != 64'd0)});
        end else begin
            n_cres = r_pb0 + r_q;
        end
        n_cval  = n_cres[63:32];
        n_rsum  = {1'b0, r_r} + {1'b0, r_rs};
        n_cy    = (n_rsum >= {1'b0, r_d});
        n_rnext = n_cy ? (n_rsum - {1'b0, r_d}) : n_rsum;
        n_qnext = r_q + r_qs + {63'd0, n_cy};
    end

    always_comb begin
        case (i_cmd.src)
            SRC_SINGLE: begin
                n_idx = r_ja0[5:0];
                n_b0  = r_jb0;
                n_b1  = r_jb1;
            end
            SRC_FIRST: begin
                n_idx = r_ja0[5:0];
                n_b0  = r_jb0;
                n_b1  = n_cval;
            end
            SRC_LOOP: begin
                n_idx = 6'(r_j);
                n_b0  = r_prev;
                n_b1  = n_cval;
            end
            SRC_LAST: begin
                n_idx = r_ja1[5:0];
                n_b0  = r_prev;
                n_b1  = r_jb1;
            end
            default: begin
                n_idx = '0;
                n_b0  = '0;
                n_b1  = '0;
            end
        endcase
        n_lo  = ($signed(n_b0) < $signed(n_b1)) ? n_b0 : n_b1;
        n_hi  = ($signed(n_b0) < $signed(n_b1)) ? n_b1 : n_b0;
        n_lim = $signed({1'b0, nb32});
        n_loc = n_lo[31] ? 33'sd0 : $signed({n_lo[31], n_lo});
        n_hic = ($signed({n_hi[31], n_hi}) >= n_lim) ? (n_lim - 33'sd1)
                                                     : $signed({n_hi[31], n_hi});
        if (r_swap) begin
            o_run.x_first = n_loc[5:0];
            o_run.x_final = n_hic[5:0];
            o_run.y_first = n_idx;
            o_run.y_final = n_idx;
        end else begin
            o_run.x_first = n_idx;
            o_run.x_final = n_idx;
            o_run.y_first = n_loc[5:0];
            o_run.y_final = n_hic[5:0];
        end
    end

    always_comb begin
        o_sts.reject = r_ja1[31] || ($signed(r_ja0) >= $signed(na32))
                    || ($signed(r_jb0) < 0 && $signed(r_jb1) < 0)
                    || ($signed(r_jb0) >= $signed(nb32) && $signed(r_jb1) >= $signed(nb32));
        o_sts.single        = (r_ja0 == r_ja1);
        o_sts.first_ok      = !r_ja0[31];
        o_sts.last_ok       = $signed(r_ja1) < $signed(na32);
        o_sts.j_lt_stop     = (r_j < r_stop);
        o_sts.div_busy      = div_busy;
        o_sts.cand_nonempty = (n_loc <= n_hic);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_cmd.mul_en;
        end
        if (i_cmd.mul_en) begin
            r_prod <= n_prod[63:0];
            r_pdst <= i_cmd.mul_op;
        end
        if (i_cmd.load) begin
            r_x0 <= i_seg[31:0];
            r_y0 <= i_seg[63:32];
            r_x1 <= i_seg[95:64];
            r_y1 <= i_seg[127:96];
        end
        if (r_pv) begin
            case (r_pdst)
                MUL_PX0: r_px0 <= r_prod;
                MUL_PX1: r_px1 <= r_prod;
                MUL_PY0: r_py0 <= r_prod;
                MUL_PY1: r_py1 <= r_prod;
                MUL_DX:  r_dx  <= r_prod;
                MUL_DY:  r_dy  <= r_prod;
                MUL_LL:  r_acc <= r_acc + {64'd0, r_prod};
                MUL_LH:  r_acc <= r_acc + {32'd0, r_prod, 32'd0};
                MUL_HL:  r_acc <= r_acc + {32'd0, r_prod, 32'd0};
                MUL_HH:  r_acc <= r_acc + {r_prod, 64'd0};
                default: r_acc <= r_acc;
            endcase
        end
        if (i_cmd.classify) begin
            r_swap <= (n_adx > n_ady);
        end
        if (i_cmd.order) begin
            r_na  <= r_swap ? n_h : n_w;
            r_nb  <= r_swap ? n_w : n_h;
            r_pa0 <= n_oswap ? n_pa1 : n_pa0;
            r_pa1 <= n_oswap ? n_pa0 : n_pa1;
            r_pb0 <= n_oswap ? n_pb1 : n_pb0;
            r_pb1 <= n_oswap ? n_pb0 : n_pb1;
            r_ja0 <= n_oswap ? n_pa1[63:32] : n_pa0[63:32];
            r_ja1 <= n_oswap ? n_pa0[63:32] : n_pa1[63:32];
        end
        if (i_cmd.prep) begin
            r_jb0  <= r_pb0[63:32];
            r_jb1  <= r_pb1[63:32];
            r_d    <= r_pa1 - r_pa0;
            r_neg  <= $signed(r_pb1) < $signed(r_pb0);
            r_m    <= ($signed(r_pb1) < $signed(r_pb0)) ? (r_pb0 - r_pb1) : (r_pb1 - r_pb0);
            r_kb   <= n_kb;
            r_n0   <= {{(32-NW){1'b0}}, n_kb, 32'd0} - r_pa0;
            r_stop <= ($signed(r_ja1) < $signed(na32)) ? NW'(r_ja1) : r_na;
            r_acc  <= '0;
        end
        if (i_cmd.save_q0) begin
            r_q <= div_q;
            r_r <= div_r;
        end
        if (i_cmd.save_step) begin
            r_qs <= div_q;
            r_rs <= div_r;
        end
        if (i_cmd.first_init) begin
            r_prev <= n_cval;
            r_j    <= r_kb;
        end
        if (i_cmd.advance) begin
            r_q <= n_qnext;
            r_r <= n_rnext[63:0];
        end
        if (i_cmd.step_next) begin
            r_prev <= n_cval;
            r_j    <= r_j + 1'b1;
        end
    end

endmodule

FILE: rtl/spr_ctrl.sv
// ----------------------------------------------------------------------------
// spr_ctrl
// Sequencer that walks one segment through setup, division and stepping.
// ----------------------------------------------------------------------------
module spr_ctrl
    import spr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    input  logic i_buf_ready,
    output t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_MUL, S_MULW, S_CLASS, S_ORDER, S_PREP, S_DECIDE, S_SINGLE,
        S_PPROD, S_PPRODW, S_DIV1_GO, S_DIV1_WAIT, S_DIV2_GO, S_DIV2_WAIT,
        S_FIRST, S_LADV, S_LEMIT, S_LAST, S_FLUSH
    } t_state;

    t_state r_state, n_state;
    t_mulop r_op;
    logic   n_go;

    always_comb begin
        o_cmd        = '0;
        o_cmd.mul_op = r_op;
        o_cmd.src    = SRC_SINGLE;
        n_state      = r_state;
        n_go         = !i_sts.cand_nonempty || i_buf_ready;
        o_in_ready   = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                if (r_op == MUL_DY) n_state = S_MULW;
            end
            S_MULW:   n_state = S_CLASS;
            S_CLASS: begin
                o_cmd.classify = 1'b1;
                n_state = S_ORDER;
            end
            S_ORDER: begin
                o_cmd.order = 1'b1;
                n_state = S_PREP;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_sts.reject) n_state = S_FLUSH;
                else if (i_sts.single) n_state = S_SINGLE;
                else n_state = S_PPROD;
            end
            S_SINGLE: begin
                o_cmd.emit = 1'b1;
                o_cmd.src  = SRC_SINGLE;
                if (n_go) n_state = S_FLUSH;
            end
            S_PPROD: begin
                o_cmd.mul_en = 1'b1;
                if (r_op == MUL_HH) n_state = S_PPRODW;
            end
            S_PPRODW: n_state = S_DIV1_GO;
            S_DIV1_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DSEL_PRODUCT;
                n_state = S_DIV1_WAIT;
            end
            S_DIV1_WAIT: begin
                if (!i_sts.div_busy) begin
                    o_cmd.save_q0 = 1'b1;
                    n_state = S_DIV2_GO;
                end
            end
            S_DIV2_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DSEL_STEP;
                n_state = S_DIV2_WAIT;
            end
            S_DIV2_WAIT: begin
                if (!i_sts.div_busy) begin
                    o_cmd.save_step = 1'b1;
                    n_state = S_FIRST;
                end
            end
            S_FIRST: begin
                o_cmd.src  = SRC_FIRST;
                o_cmd.emit = i_sts.first_ok;
                if (!i_sts.first_ok || n_go) begin
                    o_cmd.first_init = 1'b1;
                    n_state = S_LADV;
                end
            end
            S_LADV: begin
                if (i_sts.j_lt_stop) begin
                    o_cmd.advance = 1'b1;
                    n_state = S_LEMIT;
                end else begin
                    n_state = S_LAST;
                end
            end
            S_LEMIT: begin
                o_cmd.src  = SRC_LOOP;
                o_cmd.emit = 1'b1;
                if (n_go) begin
                    o_cmd.step_next = 1'b1;
                    n_state = S_LADV;
                end
            end
            S_LAST: begin
                o_cmd.src  = SRC_LAST;
                o_cmd.emit = i_sts.last_ok;
                if (!i_sts.last_ok || n_go) n_state = S_FLUSH;
            end
            S_FLUSH: begin
                o_cmd.flush = 1'b1;
                if (i_buf_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= MUL_PX0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE) begin
                r_op <= MUL_PX0;
            end else if (r_state == S_DECIDE) begin
                r_op <= MUL_LL;
            end else if (o_cmd.mul_en) begin
                r_op <= t_mulop'(r_op + 4'd1);
            end
        end
    end

endmodule

FILE: rtl/spr_outbuf.sv
// ----------------------------------------------------------------------------
// spr_outbuf
// Holds one run back so the final run of a segment can carry its last flag.
// ----------------------------------------------------------------------------
module spr_outbuf
    import spr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_run i_run,
    input  logic i_flush,
    output logic o_ready,
    output logic o_valid,
    input  logic i_ready,
    output t_run o_run,
    output logic o_last
);

    logic r_pv, r_ov, r_last;
    t_run r_pend, r_out;
    logic n_load;

    assign o_ready = !r_pv || !r_ov || i_ready;
    assign n_load  = o_ready && r_pv && (i_push || i_flush);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (n_load) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
            if (o_ready && i_push) begin
                r_pv <= 1'b1;
            end else if (o_ready && i_flush) begin
                r_pv <= 1'b0;
            end
        end
        if (n_load) begin
            r_out  <= r_pend;
            r_last <= i_flush;
        end
        if (o_ready && i_push) begin
            r_pend <= i_run;
        end
    end

    assign o_valid = r_ov;
    assign o_run   = r_out;
    assign o_last  = r_last;

endmodule

FILE: rtl/spr_checker.sv
// ----------------------------------------------------------------------------
// spr_checker
// Port-level checks of the rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module spr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("Stalled run changed.");

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("Second request taken while a segment was in work.");

    a_run_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[5:0] <= m_axis_tdata[11:6])
            && (m_axis_tdata[17:12] <= m_axis_tdata[23:18])
            && ((m_axis_tdata[5:0] == m_axis_tdata[11:6])
                || (m_axis_tdata[17:12] == m_axis_tdata[23:18])))
        else $error("Run is not a single row or column.");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("Run shown right after reset.");

endmodule

bind segment_pixel_span_raster_top spr_checker u_chk (.*);

FILE: tb/segment_pixel_span_raster_top_tb.sv
// ----------------------------------------------------------------------------
// segment_pixel_span_raster_top_tb
// Self-checking bench for the segment pixel span rasterizer. Segments are
// sent over the input stream under several origin, scale and image size
// settings. A built-in predictor computes the expected pixel runs exactly,
// and a checker compares every run against the oldest expected one.
// ----------------------------------------------------------------------------
module segment_pixel_span_raster_top_tb;

    localparam int LIMIT_DIM    = 64;
    localparam int MAX_CYCLES   = 2000000;
    localparam int DRAIN_CYCLES = 600;

    localparam logic [4:0] ADDR_ORIGIN_X = 5'd0;
    localparam logic [4:0] ADDR_ORIGIN_Y = 5'd4;
    localparam logic [4:0] ADDR_SCALE_X  = 5'd8;
    localparam logic [4:0] ADDR_SCALE_Y  = 5'd12;
    localparam logic [4:0] ADDR_WIDTH    = 5'd16;
    localparam logic [4:0] ADDR_HEIGHT   = 5'd20;

    typedef struct packed {
        logic       last_run;
        logic [5:0] y_final;
        logic [5:0] y_first;
        logic [5:0] x_final;
        logic [5:0] x_first;
    } t_span;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // x_start, y_start, x_end, y_end
    logic [127:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // x_first, x_final, y_first, y_final
    logic [23:0]  m_axis_tdata;
    logic         m_axis_tlast;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    segment_pixel_span_raster_top uut (.*);

    logic signed [63:0] org_x, org_y, scl_x, scl_y;
    logic [6:0]         img_w, img_h;

    t_span span_queue[$];
    int    error_count;
    int    cycle_count;
    int    sent_count;
    int    span_count;
    int    hold_off;
    bit    burst_mode;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES) begin
            $display("segment_pixel_span_raster_top test failed");
            $finish;
        end
    end

    task automatic report(input string what, input int got, input int want);
        error_count++;
        $display("mismatch at run %0d: %s got %0d expected %0d", span_count, what, got, want);
    endtask

    function automatic logic signed [63:0] floor_pix(input logic signed [63:0] v);
        return v >>> 32;
    endfunction

    // Floor of the other-axis coordinate where the segment meets boundary k.
    function automatic logic signed [63:0] boundary_cross(
        input logic signed [63:0] k, input logic signed [63:0] a0,
        input logic signed [63:0] a1, input logic signed [63:0] b0,
        input logic signed [63:0] b1);
        logic [63:0]  n, d, m, q, r, res;
        logic [127:0] prod;
        logic         neg;
        n    = (k << 32) - a0;
        d    = a1 - a0;
        neg  = b1 < b0;
        m    = neg ? b0 - b1 : b1 - b0;
        prod = {64'd0, n} * {64'd0, m};
        q    = 64'(prod / {64'd0, d});
        r    = 64'(prod % {64'd0, d});
        res  = neg ? b0 - (q + (r != 0)) : b0 + q;
        return floor_pix(res);
    endfunction

    function automatic void push_span(input bit swp, input logic signed [63:0] j,
        input logic signed [63:0] b0, input logic signed [63:0] b1,
        input logic signed [63:0] lim);
        logic signed [63:0] lo, hi;
        t_span s;
        lo = b0 < b1 ? b0 : b1;
        hi = b0 < b1 ? b1 : b0;
        if (lo < 0) lo = 0;
        if (hi >= lim) hi = lim - 1;
        if (lo > hi) return;
        s.last_run = 1'b0;
        if (swp) begin
            s.x_first = lo[5:0]; s.x_final = hi[5:0];
            s.y_first = j[5:0];  s.y_final = j[5:0];
        end else begin
            s.x_first = j[5:0];  s.x_final = j[5:0];
            s.y_first = lo[5:0]; s.y_final = hi[5:0];
        end
        span_queue.push_back(s);
    endfunction

    function automatic void predict_spans(input logic [127:0] seg);
        logic signed [63:0] x0, y0, x1, y1, w, h, px0, px1, py0, py1, dx, dy;
        logic signed [63:0] pa0, pa1, pb0, pb1, na, nb, ja0, ja1, jb0, jb1, tmp;
        logic signed [63:0] start, stop, prev, cur, j;
        logic [63:0] adx, ady;
        bit swp;
        int before_len;
        before_len = span_queue.size();
        x0  = $signed(seg[31:0]);   y0 = $signed(seg[63:32]);
        x1  = $signed(seg[95:64]);  y1 = $signed(seg[127:96]);
        w   = img_w > LIMIT_DIM ? LIMIT_DIM : img_w;
        h   = img_h > LIMIT_DIM ? LIMIT_DIM : img_h;
        px0 = (x0 - org_x) * scl_x; px1 = (x1 - org_x) * scl_x;
        py0 = (y0 - org_y) * scl_y; py1 = (y1 - org_y) * scl_y;
        dx  = (x1 - x0) * scl_x;    dy = (y1 - y0) * scl_y;
        adx = dx < 0 ? -dx : dx;
        ady = dy < 0 ? -dy : dy;
        swp = adx > ady;
        if (!swp) begin
            pa0 = px0; pa1 = px1; pb0 = py0; pb1 = py1; na = w; nb = h;
        end else begin
            pa0 = py0; pa1 = py1; pb0 = px0; pb1 = px1; na = h; nb = w;
        end
        ja0 = floor_pix(pa0); ja1 = floor_pix(pa1);
        if (ja1 < ja0) begin
            tmp = pa0; pa0 = pa1; pa1 = tmp;
            tmp = pb0; pb0 = pb1; pb1 = tmp;
            tmp = ja0; ja0 = ja1; ja1 = tmp;
        end
        jb0 = floor_pix(pb0); jb1 = floor_pix(pb1);
        if (ja1 < 0 || ja0 >= na) return;
        if ((jb0 > jb1 ? jb0 : jb1) < 0) return;
        if ((jb0 < jb1 ? jb0 : jb1) >= nb) return;
        if (ja0 == ja1) begin
            push_span(swp, ja0, jb0, jb1, nb);
        end else begin
            if (ja0 >= 0)
                push_span(swp, ja0, jb0, boundary_cross(ja0 + 1, pa0, pa1, pb0, pb1), nb);
            start = ja0 + 1 < 0 ? 0 : ja0 + 1;
            stop  = ja1 < na ? ja1 : na;
            if (start < stop) begin
                prev = boundary_cross(start, pa0, pa1, pb0, pb1);
                for (j = start; j < stop; j++) begin
                    cur = boundary_cross(j + 1, pa0, pa1, pb0, pb1);
                    push_span(swp, j, prev, cur, nb);
                    prev = cur;
                end
            end
            if (ja1 < na)
                push_span(swp, ja1, boundary_cross(ja1, pa0, pa1, pb0, pb1), jb1, nb);
        end
        if (span_queue.size() > before_len)
            span_queue[span_queue.size() - 1].last_run = 1'b1;
    endfunction

    // The receiver stalls on its own pattern, or for a long stretch on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off      <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= burst_mode ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge i_clk) begin
        t_span got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tlast, m_axis_tdata};
            if (span_queue.size() == 0) begin
                report("unexpected run", got, 0);
            end else begin
                want = span_queue.pop_front();
                if (got.x_first != want.x_first) report("x_first", got.x_first, want.x_first);
                if (got.x_final != want.x_final) report("x_final", got.x_final, want.x_final);
                if (got.y_first != want.y_first) report("y_first", got.y_first, want.y_first);
                if (got.y_final != want.y_final) report("y_final", got.y_final, want.y_final);
                if (got.last_run != want.last_run)
                    report("last_run", got.last_run, want.last_run);
            end
            span_count++;
        end
    end

    task automatic send_segment(input logic [31:0] xs, input logic [31:0] ys,
                                input logic [31:0] xe, input logic [31:0] ye);
        logic [127:0] seg;
        seg = {ye, xe, ys, xs};
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= seg;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_spans(seg);
        sent_count++;
        if (!burst_mode && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (span_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [4:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (addr)
            ADDR_ORIGIN_X: org_x = $signed(value);
            ADDR_ORIGIN_Y: org_y = $signed(value);
            ADDR_SCALE_X:  scl_x = $signed(value);
            ADDR_SCALE_Y:  scl_y = $signed(value);
            ADDR_WIDTH:    img_w = value[6:0];
            ADDR_HEIGHT:   img_h = value[6:0];
            default: ;
        endcase
    endtask

    task automatic set_view(input logic [31:0] ox, input logic [31:0] oy,
                            input logic [31:0] sx, input logic [31:0] sy,
                            input logic [6:0] w, input logic [6:0] h);
        wait_idle();
        write_reg(ADDR_ORIGIN_X, ox);
        write_reg(ADDR_ORIGIN_Y, oy);
        write_reg(ADDR_SCALE_X, sx);
        write_reg(ADDR_SCALE_Y, sy);
        write_reg(ADDR_WIDTH, {25'd0, w});
        write_reg(ADDR_HEIGHT, {25'd0, h});
    endtask

    // Coordinates mostly between -8 and 72 in physical units, otherwise random or extreme.
    function automatic logic [31:0] near_coord();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 80 << 16)) - (8 << 16));
        endcase
    endfunction

    task automatic test_directed();
        send_segment(32'h0001_8000, 32'h0002_0000, 32'h0030_4000, 32'h0010_0000);
        send_segment(32'h0005_0000, 32'h0001_0000, 32'h0008_0000, 32'h0038_8000);
        send_segment(32'h0003_4000, 32'h0003_c000, 32'h0003_8000, 32'h0003_2000);
        send_segment(32'h0010_0000, 32'h0010_0000, 32'h0010_0000, 32'h0010_0000);
        send_segment(32'hfff0_0000, 32'hfff0_0000, 32'h0050_0000, 32'h0050_0000);
        send_segment(32'h0050_0000, 32'h0001_0000, 32'h0060_0000, 32'h0002_0000);
        send_segment(32'hffe0_0000, 32'h0004_0000, 32'hfff0_0000, 32'h0008_0000);
        send_segment(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
        send_segment(32'h8000_0000, 32'h0000_0000, 32'h7fff_ffff, 32'h0001_0000);
        send_segment(32'h003f_ffff, 32'h0000_0000, 32'h0000_0000, 32'h003f_ffff);
        send_segment(32'h0020_0000, 32'h0030_0000, 32'h0002_0000, 32'h0001_0000);
        send_segment(32'hffff_ffff, 32'h0000_0001, 32'h0040_0000, 32'h0040_0000);
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
            send_segment(near_coord(), near_coord(), near_coord(), near_coord());
    endtask

    task automatic test_backpressure();
        wait_idle();
        hold_off = 3000;
        burst_mode = 1'b1;
        test_random(8);
        burst_mode = 1'b0;
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0; s_axis_tvalid = 1'b0; s_axis_tdata = '0; psel = 1'b0;
        penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        error_count = 0; cycle_count = 0; sent_count = 0; span_count = 0;
        hold_off = 0; burst_mode = 1'b0;
        org_x = 0; org_y = 0; scl_x = 65536; scl_y = 65536; img_w = 64; img_h = 64;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(60);
        test_backpressure();
        set_view(32'h0002_8000, 32'hfffc_0000, 32'h0002_0000, 32'h0000_8000, 7'd1, 7'd64);
        test_directed();
        test_random(40);
        set_view(32'h7fff_ffff, 32'h8000_0000, 32'hffff_0000, 32'h8000_0000, 7'd64, 7'd1);
        test_random(20);
        set_view(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h7fff_ffff, 7'd127, 7'd0);
        test_random(20);
        set_view(32'hfffe_0000, 32'h0001_0000, 32'h0001_8000, 32'hffff_0000, 7'd33, 7'd17);
        test_random(60);
        set_view(32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 7'd64, 7'd64);
        test_random(78);
        wait_idle();

        $display("Sent %0d segments under six views, %0d runs checked.",
                 sent_count, span_count);
        if (error_count == 0)
            $display("segment_pixel_span_raster_top test passed");
        else
            $display("segment_pixel_span_raster_top test failed");
        $finish;
    end
endmodule

FILE: segment_pixel_span_raster_top.f
rtl/spr_pkg.sv
rtl/spr_div.sv
rtl/spr_datapath.sv
rtl/spr_ctrl.sv
rtl/spr_outbuf.sv
rtl/segment_pixel_span_raster_top.sv
rtl/spr_checker.sv
tb/segment_pixel_span_raster_top_tb.sv
